>>> hdl/tcp_listener_echo_step_macros.svh
// assertion helpers used by the rtl
`ifndef TCP_LISTENER_ECHO_STEP_MACROS_SVH
`define TCP_LISTENER_ECHO_STEP_MACROS_SVH

// condition implies consequence in the same cycle
`define TLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tle_pkg.sv
package tle_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_OPENED = 2'd1,
    KIND_CLOSED = 2'd2,
    KIND_DATA   = 2'd3
  } kind_e;

  // register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_LISTEN_PORT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_INIT_SEQ    = 1'd1;
  localparam int unsigned CfgDataW = 32;

  // register reset values
  localparam logic [15:0] ListenPortRst = 16'd1234;
  localparam logic [31:0] InitSeqRst    = 32'h0000_1000;

  // tcp flag bits and reply flag codes
  localparam logic [7:0] FLAG_FIN     = 8'h01;
  localparam logic [7:0] FLAG_SYN     = 8'h02;
  localparam logic [7:0] FLAG_ACK     = 8'h10;
  localparam logic [7:0] FLAGS_RST    = 8'h04;
  localparam logic [7:0] FLAGS_SYNACK = 8'h12;
  localparam logic [7:0] FLAGS_FINACK = 8'h11;
  localparam logic [7:0] FLAGS_PSHACK = 8'h18;

  localparam logic [15:0] MinHdrBytes  = 16'd20;
  localparam logic [15:0] MaxEchoBytes = 16'd512;

  typedef struct packed {
    logic [15:0] segment_length;
    logic [3:0]  data_offset;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [7:0]  tcp_flags;
    logic [31:0] peer_address;
  } seg_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [31:0] peer;
    logic [15:0] length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        connected;
    logic [31:0] own_next_seq;
  } conn_t;

endpackage

>>> hdl/tle_stream_if.sv
// segment header channel
interface tle_seg_if;
  logic        valid;
  logic        ready;
  logic [15:0] segment_length;
  logic [3:0]  data_offset;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [7:0]  tcp_flags;
  logic [31:0] peer_address;

  modport source (
    output valid, segment_length, data_offset, source_port, dest_port,
           seq_number, ack_number, tcp_flags, peer_address,
    input  ready
  );
  modport sink (
    input  valid, segment_length, data_offset, source_port, dest_port,
           seq_number, ack_number, tcp_flags, peer_address,
    output ready
  );
endinterface

// result channel
interface tle_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] out_source_port;
  logic [15:0] out_dest_port;
  logic [31:0] out_seq;
  logic [31:0] out_ack;
  logic [7:0]  out_flags;
  logic [31:0] out_peer;
  logic [15:0] out_length;
  logic        last;

  modport source (
    output valid, result_kind, out_source_port, out_dest_port, out_seq, out_ack,
           out_flags, out_peer, out_length, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_source_port, out_dest_port, out_seq, out_ack,
           out_flags, out_peer, out_length, last,
    output ready
  );
endinterface

>>> hdl/tle_decide.sv
module tle_decide import tle_pkg::*; #(
  parameter logic [15:0] EchoLimit = MaxEchoBytes
) (
  input  seg_t        seg_i,
  input  conn_t       conn_i,
  input  logic [15:0] listen_port_i,
  input  logic [31:0] init_seq_i,
  output logic [1:0]  n_o,
  output res_t        res0_o,
  output res_t        res1_o,
  output conn_t       conn_o
);

  logic [5:0]  hdr_len;
  logic [15:0] hdr_len_w;
  logic [15:0] pay_len;
  logic [15:0] echo_len;
  logic        malformed;
  logic [31:0] seq_plus1;
  logic [31:0] seq_plus_pay;
  logic [31:0] own_syn;
  logic        is_syn;
  logic        ack_match;
  res_t        ev;
  res_t        seg;

  // header checks and payload length
  assign hdr_len   = {seg_i.data_offset, 2'b00};
  assign hdr_len_w = {10'd0, hdr_len};
  assign malformed = (seg_i.segment_length < MinHdrBytes) || (hdr_len_w < MinHdrBytes) ||
                     (seg_i.segment_length < hdr_len_w);
  assign pay_len   = seg_i.segment_length - hdr_len_w;
  assign echo_len  = (pay_len > EchoLimit) ? EchoLimit : pay_len;

  assign seq_plus1    = seg_i.seq_number + 32'd1;
  assign seq_plus_pay = seg_i.seq_number + {16'd0, pay_len};

  // own sequence as seen after an optional syn-ack
  assign is_syn    = (seg_i.tcp_flags & FLAG_SYN) != 8'd0;
  assign own_syn   = is_syn ? init_seq_i + 32'd1 : conn_i.own_next_seq;
  assign ack_match = ((seg_i.tcp_flags & FLAG_ACK) != 8'd0) &&
                     (seg_i.ack_number == own_syn);

  // templates: event and segment from the listening port to the peer
  always_comb begin
    ev        = '0;
    ev.kind   = KIND_OPENED;
    ev.sport  = listen_port_i;
    ev.dport  = seg_i.source_port;
    ev.peer   = seg_i.peer_address;
    seg       = ev;
    seg.kind  = KIND_SEND;
  end

  // protocol decision
  always_comb begin
    n_o    = 2'd0;
    res0_o = seg;
    res1_o = ev;
    conn_o = conn_i;
    if (!malformed) begin
      if (!conn_i.connected) begin
        if (seg_i.dest_port != listen_port_i) begin
          // reset to a closed port, ports swapped
          n_o          = 2'd1;
          res0_o.sport = seg_i.dest_port;
          res0_o.seq   = '0;
          res0_o.ack   = seq_plus1;
          res0_o.flags = FLAGS_RST;
        end else begin
          conn_o.own_next_seq = own_syn;
          if (ack_match) begin
            conn_o.connected = 1'b1;
          end
          if (is_syn) begin
            res0_o.seq   = init_seq_i;
            res0_o.ack   = seq_plus1;
            res0_o.flags = FLAGS_SYNACK;
            res1_o.kind  = KIND_OPENED;
            n_o          = ack_match ? 2'd2 : 2'd1;
          end else if (ack_match) begin
            res0_o      = ev;
            res0_o.kind = KIND_OPENED;
            n_o         = 2'd1;
          end
        end
      end else if ((seg_i.tcp_flags & FLAG_FIN) != 8'd0) begin
        // fin-ack then closed event
        n_o                 = 2'd2;
        res0_o.seq          = conn_i.own_next_seq;
        res0_o.ack          = seq_plus1;
        res0_o.flags        = FLAGS_FINACK;
        res1_o.kind         = KIND_CLOSED;
        conn_o.connected    = 1'b0;
        conn_o.own_next_seq = conn_i.own_next_seq + 32'd1;
      end else if (pay_len != 16'd0) begin
        // data event then echo
        n_o                 = 2'd2;
        res0_o              = ev;
        res0_o.kind         = KIND_DATA;
        res0_o.length       = pay_len;
        res1_o              = seg;
        res1_o.seq          = conn_i.own_next_seq;
        res1_o.ack          = seq_plus_pay;
        res1_o.flags        = FLAGS_PSHACK;
        res1_o.length       = echo_len;
        conn_o.own_next_seq = conn_i.own_next_seq + {16'd0, pay_len};
      end
    end
    res0_o.last = (n_o == 2'd1);
    res1_o.last = 1'b1;
  end

endmodule

>>> hdl/tcp_listener_echo_step.sv
// Passive single-connection tcp endpoint with echo. Each segment header is
// taken into an input register, decided there, and its zero to two results
// land in a two-entry result buffer that drains one result per cycle while
// the result port is ready. A header enters in any cycle in which the previous
// one has moved on, so with a ready port items with one result run at one
// per cycle, while one with two results holds the next back until its second
// result is taken, set by the single result port. The first result is offered
// once the item moves into the buffer when it has room. Echo length is clamped
// to EchoLimit bytes. Configuration writes (listen port at index 0, initial
// sequence at index 1) take effect at once.
`include "tcp_listener_echo_step_macros.svh"

module tcp_listener_echo_step import tle_pkg::*; #(
  parameter logic [15:0] EchoLimit = MaxEchoBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tle_seg_if.sink             seg_i,
  tle_res_if.source           res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic        in_vld_q;
  seg_t        in_q;
  logic [1:0]  cnt_q, cnt_d;
  res_t        res_q [2];
  res_t        res_d [2];
  conn_t       conn_q;
  logic [15:0] listen_port_q;
  logic [31:0] init_seq_q;

  logic [1:0]  dec_n;
  res_t        dec_r0, dec_r1;
  conn_t       dec_conn;
  logic        seg_take, out_take, buf_free, adv;

  // decision on the registered header
  tle_decide #(
    .EchoLimit (EchoLimit)
  ) u_decide (
    .seg_i         (in_q),
    .conn_i        (conn_q),
    .listen_port_i (listen_port_q),
    .init_seq_i    (init_seq_q),
    .n_o           (dec_n),
    .res0_o        (dec_r0),
    .res1_o        (dec_r1),
    .conn_o        (dec_conn)
  );

  // handshakes
  assign out_take    = res_o.valid && res_o.ready;
  assign buf_free    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_take);
  assign adv         = in_vld_q && (buf_free || (dec_n == 2'd0));
  assign seg_i.ready = !in_vld_q || adv;
  assign seg_take    = seg_i.valid && seg_i.ready;

  // result buffer next state
  always_comb begin
    cnt_d    = cnt_q;
    res_d[0] = res_q[0];
    res_d[1] = res_q[1];
    if (adv && (dec_n != 2'd0)) begin
      cnt_d    = dec_n;
      res_d[0] = dec_r0;
      res_d[1] = dec_r1;
    end else if (out_take) begin
      cnt_d    = cnt_q - 2'd1;
      res_d[0] = res_q[1];
    end
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      cnt_q         <= 2'd0;
      conn_q        <= '0;
      listen_port_q <= ListenPortRst;
      init_seq_q    <= InitSeqRst;
    end else begin
      if (seg_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      cnt_q <= cnt_d;
      if (adv) begin
        conn_q <= dec_conn;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LISTEN_PORT: listen_port_q <= cfg_data_i[15:0];
          CFG_INIT_SEQ:    init_seq_q    <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (seg_take) begin
      in_q.segment_length <= seg_i.segment_length;
      in_q.data_offset    <= seg_i.data_offset;
      in_q.source_port    <= seg_i.source_port;
      in_q.dest_port      <= seg_i.dest_port;
      in_q.seq_number     <= seg_i.seq_number;
      in_q.ack_number     <= seg_i.ack_number;
      in_q.tcp_flags      <= seg_i.tcp_flags;
      in_q.peer_address   <= seg_i.peer_address;
    end
    res_q[0] <= res_d[0];
    res_q[1] <= res_d[1];
  end

  // result port
  assign res_o.valid           = (cnt_q != 2'd0);
  assign res_o.result_kind     = res_q[0].kind;
  assign res_o.out_source_port = res_q[0].sport;
  assign res_o.out_dest_port   = res_q[0].dport;
  assign res_o.out_seq         = res_q[0].seq;
  assign res_o.out_ack         = res_q[0].ack;
  assign res_o.out_flags       = res_q[0].flags;
  assign res_o.out_peer        = res_q[0].peer;
  assign res_o.out_length      = res_q[0].length;
  assign res_o.last            = res_q[0].last;

  // checks
  `TLE_ASSERT_NOW(a_buf_cnt, 1'b1, cnt_q != 2'd3, "result buffer overfilled")
  `TLE_ASSERT_NOW(a_first_of_pair, cnt_q == 2'd2, !res_q[0].last, "last set on first of pair")
  `TLE_ASSERT_NEXT(a_pair_drain, (cnt_q == 2'd2) && out_take,
                   (cnt_q == 2'd1) && res_q[0].last, "pair did not drain to its last result")
  `TLE_ASSERT_NOW(a_open_state, res_o.valid && (res_o.result_kind == KIND_OPENED),
                  conn_q.connected, "opened event without connection")

endmodule
